FILE: rtl/wrc_pkg.sv
// Shared constants, types and the remainder digit step for the weighted choice core.
// No dependencies; used by rtl/weighted_random_choice_core.sv.
`default_nettype none

package wrc_pkg;

	// Register file and field widths
	localparam int REG_COUNT   = 8;
	localparam int NUM_ENTRIES = 8;
	localparam int CFG_IDX_W   = $clog2(REG_COUNT);
	localparam int WEIGHT_W    = 16;
	localparam int RND_W       = 31;
	localparam int IDX_W       = 3;
	localparam int SUM_W       = 19;

	// Remainder pipeline: dividend padded to DIV_W, DIGIT_BITS quotient bits per stage
	localparam int DIV_W      = 32;
	localparam int DIGIT_BITS = 4;
	localparam int DIV_STAGES = DIV_W / DIGIT_BITS;

	// Input hold after a weight write while the prefix sums settle
	localparam int SETTLE_CYCLES = 3;
	localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [WEIGHT_W-1:0] weight_t;

	// Shift DIGIT_BITS dividend bits into the partial remainder, restoring style
	function automatic sum_t div_step(input sum_t rem, input logic [DIGIT_BITS-1:0] bits,
			input sum_t divisor);
		sum_t       r;
		logic [SUM_W:0] t;
		r = rem;
		for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[SUM_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/weighted_random_choice_core.sv
// Pipeline: 8 remainder stages and 1 select stage between input transfer and result.
// Throughput: one item per cycle while in_stall is low; a stalled output only holds the stages that are full.
// The remainder unit retires 4 dividend bits per stage against the registered weight total.
// After a weight write the input stalls while the prefix sums settle.
// Reset (arst_n, async, active low) clears all weights to zero and empties the pipeline.
// Roulette-wheel selection core built on wrc_pkg: weights, prefix sums, remainder, select.
`default_nettype none

module weighted_random_choice_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_wen,
	input  wire logic [wrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wrc_pkg::WEIGHT_W-1:0]  cfg_data,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [wrc_pkg::RND_W-1:0]     random_value,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [wrc_pkg::IDX_W-1:0]          chosen_index,
	output logic                               choice_valid,
	output logic [wrc_pkg::SUM_W-1:0]          reduced_roll
);

	localparam int LAST = wrc_pkg::DIV_STAGES - 1;

	wrc_pkg::weight_t weight_q [wrc_pkg::REG_COUNT];
	wrc_pkg::sum_t    lvl0     [wrc_pkg::REG_COUNT];
	wrc_pkg::sum_t    pfx1_q   [wrc_pkg::REG_COUNT];
	wrc_pkg::sum_t    pfx2_q   [wrc_pkg::REG_COUNT];
	wrc_pkg::sum_t    pfx3_q   [wrc_pkg::REG_COUNT];
	wrc_pkg::sum_t    total;
	logic [wrc_pkg::SETTLE_W-1:0] settle_q;

	logic                        div_v_s   [wrc_pkg::DIV_STAGES];
	wrc_pkg::sum_t               div_rem_s [wrc_pkg::DIV_STAGES];
	logic [wrc_pkg::DIV_W-1:0]   div_num_s [wrc_pkg::DIV_STAGES-1];
	logic                        rdy       [wrc_pkg::DIV_STAGES];
	logic                        out_rdy;
	logic [wrc_pkg::DIV_W-1:0]   num_in;

	logic                        out_valid_q;
	logic [wrc_pkg::IDX_W-1:0]   chosen_index_q;
	logic                        choice_valid_q;
	wrc_pkg::sum_t               reduced_roll_q;

	logic [wrc_pkg::IDX_W-1:0]   pick;
	logic                        any_weight;

	// Weight registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wrc_pkg::REG_COUNT; i++) begin
				weight_q[i] <= '0;
			end
		end else if (cfg_wen) begin
			weight_q[cfg_index] <= cfg_data;
		end
	end

	// Drop entries beyond the used count
	always_comb begin
		for (int i = 0; i < wrc_pkg::REG_COUNT; i++) begin
			lvl0[i] = (i < wrc_pkg::NUM_ENTRIES) ? wrc_pkg::SUM_W'(weight_q[i]) : '0;
		end
	end

	// Registered prefix-sum tree, offsets 1, 2 and 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wrc_pkg::REG_COUNT; i++) begin
				pfx1_q[i] <= '0;
				pfx2_q[i] <= '0;
				pfx3_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < wrc_pkg::REG_COUNT; i++) begin
				if (i >= 1) begin
					pfx1_q[i] <= lvl0[i] + lvl0[i-1];
				end else begin
					pfx1_q[i] <= lvl0[i];
				end
				if (i >= 2) begin
					pfx2_q[i] <= pfx1_q[i] + pfx1_q[i-2];
				end else begin
					pfx2_q[i] <= pfx1_q[i];
				end
				if (i >= 4) begin
					pfx3_q[i] <= pfx2_q[i] + pfx2_q[i-4];
				end else begin
					pfx3_q[i] <= pfx2_q[i];
				end
			end
		end
	end

	assign total      = pfx3_q[wrc_pkg::NUM_ENTRIES-1];
	assign any_weight = (total != '0);

	// Hold off input transfers while the prefix tree catches up with a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= '0;
		end else if (cfg_wen) begin
			settle_q <= wrc_pkg::SETTLE_W'(wrc_pkg::SETTLE_CYCLES);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// Per-stage advance: a stage moves when empty or when the next one moves
	assign out_rdy = !out_valid_q || !out_stall;

	always_comb begin
		rdy[LAST] = !div_v_s[LAST] || out_rdy;
		for (int j = LAST - 1; j >= 0; j--) begin
			rdy[j] = !div_v_s[j] || rdy[j+1];
		end
	end

	assign in_stall = !rdy[0] || cfg_wen || (settle_q != '0);
	assign num_in   = wrc_pkg::DIV_W'(random_value);

	// Remainder pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < wrc_pkg::DIV_STAGES; j++) begin
				div_v_s[j] <= 1'b0;
			end
		end else begin
			if (rdy[0]) begin
				div_v_s[0] <= in_valid && !in_stall;
			end
			for (int j = 1; j < wrc_pkg::DIV_STAGES; j++) begin
				if (rdy[j]) begin
					div_v_s[j] <= div_v_s[j-1];
				end
			end
		end
	end

	// Remainder pipeline data: retire DIGIT_BITS dividend bits per stage
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			div_rem_s[0] <= wrc_pkg::div_step('0,
				num_in[wrc_pkg::DIV_W-1 -: wrc_pkg::DIGIT_BITS], total);
			div_num_s[0] <= num_in << wrc_pkg::DIGIT_BITS;
		end
		for (int j = 1; j < wrc_pkg::DIV_STAGES; j++) begin
			if (rdy[j]) begin
				div_rem_s[j] <= wrc_pkg::div_step(div_rem_s[j-1],
					div_num_s[j-1][wrc_pkg::DIV_W-1 -: wrc_pkg::DIGIT_BITS], total);
			end
		end
		// Shift the remaining dividend bits along; the last stage needs none
		for (int j = 1; j < LAST; j++) begin
			if (rdy[j]) begin
				div_num_s[j] <= div_num_s[j-1] << wrc_pkg::DIGIT_BITS;
			end
		end
	end

	// Pick the lowest entry whose prefix sum exceeds the reduced roll
	always_comb begin
		pick = '0;
		for (int i = wrc_pkg::REG_COUNT - 1; i >= 0; i--) begin
			if ((i < wrc_pkg::NUM_ENTRIES) && (div_rem_s[LAST] < pfx3_q[i])) begin
				pick = wrc_pkg::IDX_W'(i);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid_q <= div_v_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			chosen_index_q <= any_weight ? pick : '0;
			choice_valid_q <= any_weight;
			reduced_roll_q <= any_weight ? div_rem_s[LAST] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_index = chosen_index_q;
	assign choice_valid = choice_valid_q;
	assign reduced_roll = reduced_roll_q;

	// A weight write always blocks the next input transfer
	a_settle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cfg_wen) |-> in_stall)
		else $error("input accepted right after a weight write");

	// An accepted input fills the first remainder stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> div_v_s[0])
		else $error("accepted input lost at pipeline entry");

	// A full last stage behind a stalled output is held
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && div_v_s[LAST]) |=> div_v_s[LAST])
		else $error("last remainder stage dropped under stall");

	// No choice means all result fields are zero
	a_no_choice: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !choice_valid_q) |-> (chosen_index_q == '0 && reduced_roll_q == '0))
		else $error("empty choice carries nonzero fields");

endmodule

`default_nettype wire
